// File: rtl/fbsa_pkg.sv
package fbsa_pkg;

  // Map geometry
  localparam int SLOTS     = 256;
  localparam int MAP_BYTES = SLOTS / 8;
  localparam int ADDR_W    = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;
  localparam int CNT_W     = $clog2(MAP_BYTES + 1);
  localparam int LIM_W     = (CNT_W > 6) ? CNT_W : 6;

  localparam logic [2:0] BIT_SEL = 3'h7;

  // Function codes
  localparam logic [2:0] FN_FIND     = 3'd0;
  localparam logic [2:0] FN_RELEASE  = 3'd1;
  localparam logic [2:0] FN_CLAIM    = 3'd2;
  localparam logic [2:0] FN_LOAD_MAP = 3'd3;
  localparam logic [2:0] FN_LOAD_CNT = 3'd4;

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [LIM_W-1:0]  lim_t;

  typedef struct packed {
    logic [2:0] func;
    logic [7:0] slot_index;
    logic [8:0] load_value;
  } item_t;

  typedef struct packed {
    logic       status;
    logic [7:0] free_slot;
    logic [8:0] free_total;
  } result_t;

  // Controller to datapath
  typedef struct packed {
    logic clear_wr;
    logic capture;
    logic scan_step;
    logic apply;
    logic find_done;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clear_last;
    logic is_find;
    logic scan_hit;
    logic scan_miss;
  } sts_t;

endpackage

// File: rtl/fbsa_ram.sv
module fbsa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/fbsa_ctrl.sv
module fbsa_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  fbsa_pkg::sts_t sts,
  output fbsa_pkg::cmd_t cmd,
  output logic          busy
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_MOD_RD,
    ST_MOD_WR
  } state_t;

  state_t state, state_next;

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_CLEAR: begin
        cmd.clear_wr = 1'b1;
        if (sts.clear_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          state_next  = sts.is_find ? ST_SCAN : ST_MOD_RD;
        end
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_hit || sts.scan_miss) begin
          cmd.find_done = 1'b1;
          state_next    = ST_IDLE;
        end
      end
      ST_MOD_RD: begin
        state_next = ST_MOD_WR;
      end
      ST_MOD_WR: begin
        cmd.apply  = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // State and busy flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      busy  <= 1'b1;
    end else begin
      state <= state_next;
      busy  <= (state_next != ST_IDLE);
    end
  end

endmodule

// File: rtl/fbsa_dp.sv
module fbsa_dp (
  input  logic             clk,
  input  logic             rst,
  input  fbsa_pkg::item_t  item,
  input  logic             slot_count_we,
  input  logic [8:0]       slot_count_wdata,
  input  fbsa_pkg::cmd_t   cmd,
  output fbsa_pkg::sts_t   sts,
  output fbsa_pkg::result_t result,
  output logic             done
);

  fbsa_pkg::item_t item_q;
  logic [8:0]      slot_count;
  logic [8:0]      free_counter;
  logic [8:0]      free_counter_next;
  fbsa_pkg::addr_t clr_ptr;
  fbsa_pkg::lim_t  issue_ptr;
  fbsa_pkg::addr_t chk_ptr;
  logic            pend;
  fbsa_pkg::lim_t  limit;
  logic            issue_ok;

  logic            ram_we;
  fbsa_pkg::addr_t ram_waddr;
  logic [7:0]      ram_wdata;
  fbsa_pkg::addr_t ram_raddr;
  logic [7:0]      ram_rdata;

  logic [4:0]      byte_sel;
  fbsa_pkg::addr_t byte_addr;
  logic            in_map;
  logic [7:0]      bit_mask;
  logic            map_we;
  logic [7:0]      new_byte;
  logic [9:0]      cnt_inc;
  logic [2:0]      low_bit;

  // Item decode
  assign byte_sel  = item_q.slot_index[7:3];
  assign byte_addr = fbsa_pkg::addr_t'(byte_sel);
  assign in_map    = 32'(byte_sel) < fbsa_pkg::MAP_BYTES;
  assign bit_mask  = 8'(1) << (item_q.slot_index[2:0] & fbsa_pkg::BIT_SEL);

  // Scan bound: slot_count/8 bytes, never beyond the map
  always_comb begin
    if (fbsa_pkg::lim_t'(slot_count[8:3]) > fbsa_pkg::lim_t'(fbsa_pkg::MAP_BYTES)) begin
      limit = fbsa_pkg::lim_t'(fbsa_pkg::MAP_BYTES);
    end else begin
      limit = fbsa_pkg::lim_t'(slot_count[8:3]);
    end
  end

  assign issue_ok = issue_ptr < limit;

  // Lowest set bit of the byte under check
  always_comb begin
    low_bit = 3'd7;
    for (int i = 6; i >= 0; i--) begin
      if (ram_rdata[i]) begin
        low_bit = 3'(i);
      end
    end
  end

  // Status to controller
  assign sts.clear_last = (clr_ptr == fbsa_pkg::addr_t'(fbsa_pkg::MAP_BYTES - 1));
  assign sts.is_find    = (item.func == fbsa_pkg::FN_FIND);
  assign sts.scan_hit   = pend && (ram_rdata != 8'h00);
  assign sts.scan_miss  = !pend && !issue_ok;

  // Byte update and counter update for modify items
  always_comb begin
    map_we            = 1'b0;
    new_byte          = ram_rdata;
    free_counter_next = free_counter;
    cnt_inc           = {1'b0, free_counter} + 10'd1;
    case (item_q.func)
      fbsa_pkg::FN_RELEASE: begin
        map_we   = in_map;
        new_byte = ram_rdata | bit_mask;
        if (cnt_inc < {1'b0, slot_count}) begin
          free_counter_next = cnt_inc[8:0];
        end else begin
          free_counter_next = slot_count;
        end
      end
      fbsa_pkg::FN_CLAIM: begin
        new_byte = ram_rdata & ~bit_mask;
        if (in_map && ((ram_rdata & bit_mask) != 8'h00)) begin
          map_we = 1'b1;
          if (free_counter != 9'd0) begin
            free_counter_next = free_counter - 9'd1;
          end
        end
      end
      fbsa_pkg::FN_LOAD_MAP: begin
        map_we   = in_map;
        new_byte = item_q.load_value[7:0];
      end
      fbsa_pkg::FN_LOAD_CNT: begin
        if (item_q.load_value < slot_count) begin
          free_counter_next = item_q.load_value;
        end else begin
          free_counter_next = slot_count;
        end
      end
      default: begin
        map_we = 1'b0;
      end
    endcase
  end

  // Bitmap memory ports
  assign ram_we    = cmd.clear_wr || (cmd.apply && map_we);
  assign ram_waddr = cmd.clear_wr ? clr_ptr : byte_addr;
  assign ram_wdata = cmd.clear_wr ? 8'h00 : new_byte;
  assign ram_raddr = cmd.scan_step ? fbsa_pkg::addr_t'(issue_ptr) : byte_addr;

  fbsa_ram #(
    .WIDTH (8),
    .DEPTH (fbsa_pkg::MAP_BYTES)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_count   <= 9'd256;
      free_counter <= 9'd0;
      clr_ptr      <= '0;
      issue_ptr    <= '0;
      pend         <= 1'b0;
      done         <= 1'b0;
    end else begin
      done <= cmd.apply || cmd.find_done;
      if (slot_count_we) begin
        slot_count <= slot_count_wdata;
      end
      if (cmd.clear_wr) begin
        clr_ptr <= clr_ptr + fbsa_pkg::addr_t'(1);
      end
      if (cmd.apply) begin
        free_counter <= free_counter_next;
      end
      if (cmd.capture) begin
        issue_ptr <= '0;
        pend      <= 1'b0;
      end else if (cmd.scan_step) begin
        pend <= issue_ok;
        if (issue_ok) begin
          issue_ptr <= issue_ptr + fbsa_pkg::lim_t'(1);
        end
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_q <= item;
    end
    if (cmd.scan_step) begin
      chk_ptr <= fbsa_pkg::addr_t'(issue_ptr);
    end
    if (cmd.apply) begin
      result.status     <= 1'b0;
      result.free_slot  <= 8'd0;
      result.free_total <= free_counter_next;
    end else if (cmd.find_done) begin
      result.status     <= !sts.scan_hit;
      result.free_slot  <= sts.scan_hit ? 8'({chk_ptr, low_bit}) : 8'd0;
      result.free_total <= free_counter;
    end
  end

endmodule

// File: rtl/free_bitmap_slot_allocator_unit.sv
// Free-slot bitmap allocator. Raise start with an item while busy is low; the item is
// taken at that edge and busy stays high until its one result is posted. The result is
// on result for exactly one cycle with done high and cannot be held off, so capture it
// then. Find reads one bitmap byte per cycle from the single read port of the bitmap
// RAM and posts its result on the first nonzero byte, or a miss once slot_count/8 bytes
// (at most SLOTS/8) are read. Release, claim and both loads run a byte read, a write-back
// and a result. After reset a clearing pass zeroes the bitmap, one byte a cycle over all
// SLOTS/8 bytes (32 at 256 slots), with busy high; slot_count writes are taken
// at any time and should be made while idle.
module free_bitmap_slot_allocator_unit (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  fbsa_pkg::item_t   item,
  output logic              busy,
  output logic              done,
  output fbsa_pkg::result_t result,
  input  logic              slot_count_we,
  input  logic [8:0]        slot_count_wdata
);

  fbsa_pkg::cmd_t cmd;
  fbsa_pkg::sts_t sts;

  fbsa_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  fbsa_dp u_dp (
    .clk              (clk),
    .rst              (rst),
    .item             (item),
    .slot_count_we    (slot_count_we),
    .slot_count_wdata (slot_count_wdata),
    .cmd              (cmd),
    .sts              (sts),
    .result           (result),
    .done             (done)
  );

endmodule

// File: tb/free_bitmap_slot_allocator_unit_test.sv
module free_bitmap_slot_allocator_unit_test;
  import fbsa_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int MAX_GAP        = 16;
  localparam int ITEMS_PER_SET  = 160;
  localparam int FN_CODES       = 8;

  typedef struct {
    item_t       itm;
    int unsigned gap;
  } stim_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       start = 1'b0;
  item_t      item = '0;
  logic       busy;
  logic       done;
  result_t    result;
  logic       slot_count_we = 1'b0;
  logic [8:0] slot_count_wdata = '0;

  // Predictor state
  logic [7:0] map_img [MAP_BYTES];
  logic [8:0] free_cnt;
  logic [8:0] slot_cnt;

  stim_t      pending_items [$];
  result_t    predicted_results [$];
  bit         took_item = 1'b0;
  bit         next_start;
  int         gap_cnt = 0;
  int         idle_cycles = 0;
  int         err_cnt = 0;

  free_bitmap_slot_allocator_unit i_dut (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .item             (item),
    .busy             (busy),
    .done             (done),
    .result           (result),
    .slot_count_we    (slot_count_we),
    .slot_count_wdata (slot_count_wdata)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Predict the result of one item and update the bitmap and counter image
  function automatic result_t allocator_step(item_t it);
    result_t     res;
    int          byte_sel;
    int          lim;
    int          next_cnt;
    bit          hit;
    logic [7:0]  mask;
    res      = '0;
    byte_sel = it.slot_index[7:3];
    mask     = 8'h01 << (it.slot_index & BIT_SEL);
    case (it.func)
      FN_FIND: begin
        lim = slot_cnt >> 3;
        if (lim > MAP_BYTES) lim = MAP_BYTES;
        hit = 1'b0;
        for (int b = 0; b < lim; b++) begin
          if (!hit && map_img[b] != 8'h00) begin
            hit = 1'b1;
            for (int k = 7; k >= 0; k--) begin
              if (map_img[b][k]) res.free_slot = 8'(b * 8 + k);
            end
          end
        end
        res.status = !hit;
      end
      FN_RELEASE: begin
        if (byte_sel < MAP_BYTES) map_img[byte_sel] = map_img[byte_sel] | mask;
        next_cnt = int'(free_cnt) + 1;
        free_cnt = (next_cnt < int'(slot_cnt)) ? 9'(next_cnt) : slot_cnt;
      end
      FN_CLAIM: begin
        if (byte_sel < MAP_BYTES && (map_img[byte_sel] & mask) != 8'h00) begin
          map_img[byte_sel] = map_img[byte_sel] & ~mask;
          if (free_cnt != 0) free_cnt = free_cnt - 1'b1;
        end
      end
      FN_LOAD_MAP: begin
        if (byte_sel < MAP_BYTES) map_img[byte_sel] = it.load_value[7:0];
      end
      FN_LOAD_CNT: begin
        free_cnt = (it.load_value < slot_cnt) ? it.load_value : slot_cnt;
      end
      default: ;
    endcase
    res.free_total = free_cnt;
    return res;
  endfunction

  // Driver: presents queued items after their drawn idle gap
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
      gap_cnt = 0;
    end else begin
      next_start = start && !took_item;
      if (!next_start && pending_items.size() > 0) begin
        if (gap_cnt < pending_items[0].gap) begin
          gap_cnt++;
        end else begin
          item <= pending_items[0].itm;
          void'(pending_items.pop_front());
          next_start = 1'b1;
          gap_cnt = 0;
        end
      end
      start <= next_start;
    end
  end

  // Monitor: check posted results, predict accepted items, watchdog
  always @(posedge clk) begin
    result_t exp_res;
    took_item = 1'b0;
    if (!rst) begin
      idle_cycles++;
      if (done) begin
        idle_cycles = 0;
        if (predicted_results.size() == 0) begin
          $error("result with nothing pending: status %0d slot %0d total %0d",
                 result.status, result.free_slot, result.free_total);
          err_cnt++;
        end else begin
          exp_res = predicted_results.pop_front();
          if (result.status !== exp_res.status) begin
            $error("status: expected %0d, got %0d", exp_res.status, result.status);
            err_cnt++;
          end
          if (result.free_slot !== exp_res.free_slot) begin
            $error("free_slot: expected %0d, got %0d", exp_res.free_slot, result.free_slot);
            err_cnt++;
          end
          if (result.free_total !== exp_res.free_total) begin
            $error("free_total: expected %0d, got %0d", exp_res.free_total,
                   result.free_total);
            err_cnt++;
          end
        end
      end
      if (start && !busy) begin
        took_item = 1'b1;
        idle_cycles = 0;
        predicted_results.push_back(allocator_step(item));
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("free_bitmap_slot_allocator_unit_test: done, errors");
        $finish;
      end
    end
  end

  function automatic int unsigned draw_gap(bit bursty);
    if (bursty && $urandom_range(0, 9) != 0) return 0;
    return $urandom_range(0, MAX_GAP);
  endfunction

  function automatic item_t make_item(logic [2:0] fn, logic [7:0] idx, logic [8:0] val);
    item_t it;
    it.func       = fn;
    it.slot_index = idx;
    it.load_value = val;
    return it;
  endfunction

  // Random item, slot indexes mostly within the active slot range
  function automatic item_t rand_item(int sc);
    item_t it;
    int    sel;
    int    span;
    sel  = $urandom_range(0, 99);
    span = (sc >= 8 && sc < 256) ? sc : 256;
    if (sel < 30)      it.func = FN_FIND;
    else if (sel < 50) it.func = FN_RELEASE;
    else if (sel < 70) it.func = FN_CLAIM;
    else if (sel < 85) it.func = FN_LOAD_MAP;
    else if (sel < 95) it.func = FN_LOAD_CNT;
    else               it.func = 3'($urandom_range(FN_LOAD_CNT + 1, FN_CODES - 1));
    if ($urandom_range(0, 2) != 0) it.slot_index = 8'($urandom_range(0, span - 1));
    else                           it.slot_index = 8'($urandom_range(0, 255));
    it.load_value = 9'($urandom_range(0, 511));
    // sparse maps keep find results interesting
    if (it.func == FN_LOAD_MAP && $urandom_range(0, 2) == 0)
      it.load_value = {1'($urandom_range(0, 1)), 8'h00};
    if (it.func == FN_LOAD_CNT && $urandom_range(0, 1) == 0)
      it.load_value = 9'($urandom_range(0, sc));
    return it;
  endfunction

  task automatic queue_item(item_t it, bit bursty);
    stim_t s;
    s.itm = it;
    s.gap = draw_gap(bursty);
    pending_items.push_back(s);
  endtask

  task automatic wait_idle();
    while (pending_items.size() != 0 || start || predicted_results.size() != 0)
      @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic set_slot_count(logic [8:0] v);
    wait_idle();
    @(negedge clk);
    slot_count_we    <= 1'b1;
    slot_count_wdata <= v;
    slot_cnt = v;
    @(negedge clk);
    slot_count_we <= 1'b0;
  endtask

  int set_list [10] = '{256, 0, 511, 8, 7, 13, 100, 255, 200, 256};

  initial begin
    for (int b = 0; b < MAP_BYTES; b++) map_img[b] = 8'h00;
    free_cnt = '0;
    slot_cnt = 9'd256;
    repeat (6) @(negedge clk);
    rst <= 1'b0;

    // Directed: empty map, saturation, claim of clear bit, claim at zero count,
    // top byte, bit 8 of byte loads ignored, unused codes
    queue_item(make_item(FN_FIND,     8'd0,   9'd0),   1'b0);
    queue_item(make_item(FN_LOAD_CNT, 8'd0,   9'h1FF), 1'b0);
    queue_item(make_item(FN_RELEASE,  8'd5,   9'd0),   1'b0);
    queue_item(make_item(FN_FIND,     8'd0,   9'd0),   1'b0);
    queue_item(make_item(FN_CLAIM,    8'd5,   9'd0),   1'b0);
    queue_item(make_item(FN_CLAIM,    8'd5,   9'd0),   1'b0);
    queue_item(make_item(FN_LOAD_MAP, 8'hFF,  9'h180), 1'b0);
    queue_item(make_item(FN_FIND,     8'd0,   9'd0),   1'b0);
    queue_item(make_item(FN_RELEASE,  8'd0,   9'd0),   1'b0);
    queue_item(make_item(FN_FIND,     8'd0,   9'd0),   1'b0);
    queue_item(make_item(FN_LOAD_CNT, 8'd0,   9'd0),   1'b0);
    queue_item(make_item(FN_CLAIM,    8'hFF,  9'd0),   1'b0);
    queue_item(make_item(FN_FIND,     8'd0,   9'd0),   1'b0);
    queue_item(make_item(FN_CLAIM,    8'd0,   9'd0),   1'b0);
    queue_item(make_item(FN_FIND,     8'd0,   9'd0),   1'b0);
    queue_item(make_item(FN_LOAD_MAP, 8'h07,  9'h0FF), 1'b0);
    queue_item(make_item(FN_FIND,     8'd0,   9'd0),   1'b0);
    for (int f = FN_LOAD_CNT + 1; f < FN_CODES; f++)
      queue_item(make_item(3'(f), 8'($urandom_range(0, 255)),
                           9'($urandom_range(0, 511))), 1'b0);
    queue_item(make_item(FN_LOAD_MAP, 8'hF8,  9'h001), 1'b0);
    queue_item(make_item(FN_LOAD_CNT, 8'd0,   9'd256), 1'b0);
    queue_item(make_item(FN_RELEASE,  8'hFF,  9'd0),   1'b0);
    queue_item(make_item(FN_FIND,     8'd0,   9'd0),   1'b0);

    // Random sets, one slot count each; odd sets run mostly back to back
    foreach (set_list[s]) begin
      set_slot_count(9'(set_list[s]));
      for (int n = 0; n < ITEMS_PER_SET; n++)
        queue_item(rand_item(set_list[s]), s[0]);
    end

    wait_idle();
    repeat (40) @(posedge clk);
    if (err_cnt == 0) begin
      $display("free_bitmap_slot_allocator_unit_test: done, clean");
    end else begin
      $display("free_bitmap_slot_allocator_unit_test: done, errors");
    end
    $finish;
  end

endmodule
